// ===== hw/rtl/bitr_pkg.sv =====
// Shared types and constants for the MSB-first bit reader.
// Used by bitr_shifter, msb_first_bit_reader and bitr_checker; depends on nothing.
package bitr_pkg;

  // Field widths of the transfer payloads.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int BYTE_W  = 8;
  localparam int BLEFT_W = 4;

  // Request codes carried on in_req_type.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Largest bit count that one read returns.
  localparam logic [COUNT_W-1:0] MAX_BITS = 6'd32;

  // Unread bits in a freshly opened byte.
  localparam logic [BLEFT_W-1:0] FULL_BYTE = 4'd8;

  // Read sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXTRACT
  } state_t;

  // Result of taking one byte's worth of bits into the accumulator.
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [COUNT_W-1:0] want;
    logic [BLEFT_W-1:0] bits_left;
    logic               byte_done;
  } step_t;

endpackage

// ===== hw/rtl/msb_first_bit_reader.sv =====
// Top level of the MSB-first bit reader: request decode, read sequencer and result register.
// Depends on bitr_pkg, bitr_store and bitr_shifter.
//
//   Channel  Direction  Ports                                       Moves
//   in       input      in_valid/in_ready, req_type/data_byte/count one request
//   out      output     out_valid/out_ready, out_value/out_ok       one read result
//
// Start and append requests leave the input ready; append writes one byte to the store while it has room.
// A read is accepted, then takes bits from each stored byte it touches in turn, with one
// more step when the data runs out first; the single store read port feeds one byte a
// cycle unless a stalled result holds the last step.
// Zero-bit reads and reads at the end of data finish in their first ST_EXTRACT step.
// rst_n clears lengths and position; the store contents are not cleared.
// A stalled result holds the sequencer on its last step; requests wait while a read runs.
module msb_first_bit_reader
  import bitr_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [COUNT_W-1:0] in_bit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_ok
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);

  state_t             state_r, state_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      pos_r, pos_nxt;
  logic [BLEFT_W-1:0] bits_left_r, bits_left_nxt;
  logic [COUNT_W-1:0] want_r, want_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_ok_r, out_ok_nxt;

  logic               in_fire;
  logic               out_free;
  logic               at_end;
  logic               consume;
  logic               finish;
  logic               hold;
  logic               wr_en;
  logic [BYTE_W-1:0]  rd_byte;
  step_t              step;

  // Store of appended bytes; the read address follows the next read position.
  bitr_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (pos_nxt[AW-1:0]),
    .rd_data (rd_byte)
  );

  // Digit step over the byte at the current position.
  bitr_shifter u_shifter (
    .cur_byte  (rd_byte),
    .acc       (acc_r),
    .bits_left (bits_left_r),
    .want      (want_r),
    .step      (step)
  );

  // Handshake and step conditions.
  always_comb begin
    in_fire  = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    at_end   = (pos_r >= len_r);
    consume  = (state_r == ST_EXTRACT) && (want_r != '0) && !at_end;
    finish   = (state_r == ST_EXTRACT) &&
               ((want_r == '0) || at_end || (step.want == '0));
    hold     = finish && !out_free;
    wr_en    = in_fire && (in_req_type == REQ_APPEND) &&
               (len_r < LW'(STORE_DEPTH));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_req_type == REQ_READ)) begin
          state_nxt = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        if (finish && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
  end

  // Buffer bookkeeping and accumulator updates.
  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    bits_left_nxt = bits_left_r;
    want_nxt      = want_r;
    acc_nxt       = acc_r;
    if (in_fire) begin
      case (in_req_type)
        REQ_START: begin
          len_nxt       = '0;
          pos_nxt       = '0;
          bits_left_nxt = FULL_BYTE;
        end
        REQ_APPEND: begin
          if (wr_en) begin
            len_nxt = len_r + LW'(1);
          end
        end
        REQ_READ: begin
          want_nxt = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;
          acc_nxt  = '0;
        end
        default: ;
      endcase
    end else if (consume && !hold) begin
      acc_nxt       = step.acc;
      want_nxt      = step.want;
      bits_left_nxt = step.bits_left;
      if (step.byte_done) begin
        pos_nxt = pos_r + LW'(1);
      end
    end
  end

  // Result register: a finished read loads it, a transfer on out empties it.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    if (finish && !hold) begin
      out_valid_nxt = 1'b1;
      if (want_r == '0) begin
        out_value_nxt = '0;
        out_ok_nxt    = 1'b1;
      end else if (at_end) begin
        out_value_nxt = acc_r << want_r;
        out_ok_nxt    = 1'b0;
      end else begin
        out_value_nxt = step.acc;
        out_ok_nxt    = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      pos_r       <= '0;
      bits_left_r <= FULL_BYTE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      bits_left_r <= bits_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    want_r      <= want_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_ok    = out_ok_r;

endmodule

// ===== hw/rtl/bitr_store.sv =====
// Byte store of the bit reader: one write port, one read port with registered data.
// Standalone memory; no package needed.
module bitr_store #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write one byte per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle; the data is registered and shows in the next cycle.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/bitr_shifter.sv =====
// One digit step of the reader: takes up to eight bits from the current byte
// and shifts them into the accumulator. Depends on bitr_pkg.
module bitr_shifter
  import bitr_pkg::*;
(
  input  logic [BYTE_W-1:0]  cur_byte,
  input  logic [VALUE_W-1:0] acc,
  input  logic [BLEFT_W-1:0] bits_left,
  input  logic [COUNT_W-1:0] want,
  output step_t              step
);

  logic [BLEFT_W-1:0] take;
  logic [BLEFT_W-1:0] sh;
  logic [BLEFT_W-1:0] left_after;
  logic [BYTE_W-1:0]  mask;
  logic [BYTE_W-1:0]  chunk;

  // The step takes the smaller of what the byte holds and what is still wanted.
  always_comb begin
    if ({{(COUNT_W-BLEFT_W){1'b0}}, bits_left} < want) begin
      take = bits_left;
    end else begin
      take = want[BLEFT_W-1:0];
    end
    sh         = bits_left - take;
    mask       = ~(8'hff << take);
    chunk      = (cur_byte >> sh) & mask;
    left_after = bits_left - take;
  end

  // Merge the chunk below the bits gathered so far and advance the counters.
  always_comb begin
    step.acc       = (acc << take) | {{(VALUE_W-BYTE_W){1'b0}}, chunk};
    step.want      = want - {{(COUNT_W-BLEFT_W){1'b0}}, take};
    step.byte_done = (left_after == '0);
    step.bits_left = step.byte_done ? FULL_BYTE : left_after;
  end

endmodule

// ===== hw/rtl/bitr_checker.sv =====
// Port-level checks for msb_first_bit_reader, bound to every instance of it.
// Depends on bitr_pkg and the top level's port names.
module bitr_checker
  import bitr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] out_value,
  input logic               out_ok
);

  // A result waiting for its transfer holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ok))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A read transfer occupies the sequencer for at least the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_READ) |=> !in_ready)
    else $error("request taken during a read");

  // Start, append and unused requests finish in the cycle they are taken.
  a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != REQ_READ) |=> in_ready)
    else $error("non-read request stalled the input");

  // A result appears only at the end of a read in progress.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a running read");

endmodule

bind msb_first_bit_reader bitr_checker u_bitr_checker (.*);
